// File: hw/rtl/wwmc_pkg.sv
`default_nettype none
package wwmc_pkg;

	localparam int unsigned WINDOW    = 512;
	localparam int unsigned LEN_W     = 10;
	localparam int unsigned COST_W    = 40;
	localparam int unsigned USED_W    = LEN_W + 1;
	localparam int unsigned SQ_W      = 2 * LEN_W;
	// the newest word is handled from the incoming item, so the ring keeps one fewer
	localparam int unsigned RING      = WINDOW - 1;
	localparam int unsigned CNT_W     = $clog2(RING + 1);
	localparam logic [LEN_W-1:0]  WIDTH_RESET = LEN_W'(80);
	localparam logic [COST_W-1:0] COST_MAX    = {COST_W{1'b1}};

	// one ring entry: a word's length and the best cost of the prefix before it
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [COST_W-1:0] pb;
	} pair_t;

	typedef enum logic [1:0] {
		CH_HOLD,
		CH_UP,
		CH_DOWN,
		CH_INSERT
	} chain_op_t;

	typedef struct packed {
		chain_op_t op;
		pair_t     ins;
	} chain_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_RESTORE,
		ST_INSERT,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// File: hw/rtl/wwmc_cell.sv
`default_nettype none
module wwmc_cell (
	input  wire                 clk,
	input  wwmc_pkg::chain_op_t op,
	input  wwmc_pkg::pair_t     from_next,
	input  wwmc_pkg::pair_t     from_prev,
	output wwmc_pkg::pair_t     data
);
	import wwmc_pkg::*;

	pair_t data_q;

	always_ff @(posedge clk) begin
		case (op)
			CH_UP:                  data_q <= from_next;
			CH_DOWN, CH_INSERT:     data_q <= from_prev;
			default:                data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule
`default_nettype wire

// File: hw/rtl/wwmc_chain.sv
`default_nettype none
module wwmc_chain (
	input  wire                  clk,
	input  wwmc_pkg::chain_ctl_t ctl,
	output wwmc_pkg::pair_t      front
);
	import wwmc_pkg::*;

	pair_t cells [RING];
	pair_t prev_in [RING];
	pair_t next_in [RING];

	always_comb begin
		for (int i = 0; i < RING; i++) begin
			next_in[i] = cells[(i + 1) % RING];
			if (i == 0)
				prev_in[i] = (ctl.op == CH_INSERT) ? ctl.ins : cells[RING-1];
			else
				prev_in[i] = cells[i-1];
		end
	end

	for (genvar g = 0; g < RING; g++) begin : g_cell
		wwmc_cell u_cell (
			.clk       (clk),
			.op        (ctl.op),
			.from_next (next_in[g]),
			.from_prev (prev_in[g]),
			.data      (cells[g])
		);
	end

	assign front = cells[0];

endmodule
`default_nettype wire

// File: hw/rtl/word_wrap_min_cost_top.sv
`default_nettype none
// Each word walks back over the older words that still fit on the line with it; a
// last word then goes straight to the output state, without restore or insert.
// A new word is taken only in idle, once the last one is through the ring of cells
// that rotates one entry per cycle out to the walk and back again.
// Reset (arst_n low): line_width returns to 80, the paragraph state and out_valid clear.
module word_wrap_min_cost_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [wwmc_pkg::LEN_W-1:0]    cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [wwmc_pkg::LEN_W-1:0]    word_length,
	input  wire                           last_word,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [wwmc_pkg::COST_W-1:0]   total_cost,
	output logic                          too_long
);
	import wwmc_pkg::*;

	state_t state_q, state_d;

	logic [LEN_W-1:0]  line_width_q;
	// per-word working registers
	logic [LEN_W-1:0]  width_q;
	logic [LEN_W-1:0]  len_q;
	logic              last_q;
	logic [USED_W-1:0] used_q;
	logic [CNT_W-1:0]  walked_q;
	logic [COST_W-1:0] best_q;
	// paragraph state
	logic [CNT_W-1:0]  cnt_q;
	logic [COST_W-1:0] prev_best_q;
	logic              err_q;
	// candidate pipeline
	logic              valid_s1;
	logic [LEN_W-1:0]  extra_s1;
	logic [COST_W-1:0] pb_s1;
	// output register
	logic              out_valid_q;
	logic [COST_W-1:0] total_cost_q;
	logic              too_long_q;

	chain_ctl_t        ctl;
	pair_t             front;
	logic              accept;
	logic              first_fit;
	logic [USED_W-1:0] used_n;
	logic              walk_fit;
	logic              walk_end;
	logic [SQ_W-1:0]   sq;
	logic [COST_W:0]   sum;
	logic [COST_W-1:0] cand;
	logic              out_load;

	wwmc_chain u_chain (
		.clk   (clk),
		.ctl   (ctl),
		.front (front)
	);

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign first_fit = word_length <= line_width_q;

	// one step back: add the older word and its separating space
	assign used_n   = used_q + USED_W'(front.len) + USED_W'(1);
	assign walk_fit = used_n <= USED_W'(width_q);
	assign walk_end = (walked_q + CNT_W'(1)) == cnt_q;

	// square the slack, add the prefix cost, saturate; a last word's line costs only its prefix
	assign sq   = extra_s1 * extra_s1;
	assign sum  = {1'b0, pb_s1} + (COST_W+1)'(sq);
	assign cand = last_q ? pb_s1 : (sum[COST_W] ? COST_MAX : sum[COST_W-1:0]);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (accept)
					state_d = (first_fit && cnt_q != '0) ? ST_WALK : ST_DRAIN;
			ST_WALK:
				if (!walk_fit || walk_end)
					state_d = ST_DRAIN;
			ST_DRAIN:
				if (last_q)
					state_d = ST_OUT;
				else if (walked_q != '0)
					state_d = ST_RESTORE;
				else
					state_d = ST_INSERT;
			ST_RESTORE:
				if (walked_q == CNT_W'(1))
					state_d = ST_INSERT;
			ST_INSERT:
				state_d = ST_IDLE;
			ST_OUT:
				if (out_load)
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		ctl.op      = CH_HOLD;
		ctl.ins.len = len_q;
		ctl.ins.pb  = prev_best_q;
		unique case (state_q)
			ST_IDLE:    in_ready = 1'b1;
			ST_WALK:    if (walk_fit) ctl.op = CH_UP;
			ST_RESTORE: ctl.op = CH_DOWN;
			ST_INSERT:  ctl.op = CH_INSERT;
			default:    ctl.op = CH_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			line_width_q <= WIDTH_RESET;
			cnt_q        <= '0;
			prev_best_q  <= '0;
			err_q        <= 1'b0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				line_width_q <= cfg_data;
			// raise the result on a load, drop it once the consumer takes it
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			valid_s1 <= (state_q == ST_IDLE && accept && first_fit) ||
				(state_q == ST_WALK && walk_fit);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !first_fit)
						err_q <= 1'b1;
				end
				ST_INSERT: begin
					prev_best_q <= best_q;
					if (cnt_q != CNT_W'(RING))
						cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_OUT: begin
					if (out_load) begin
						cnt_q       <= '0;
						prev_best_q <= '0;
						err_q       <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && cand < best_q)
			best_q <= cand;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					width_q  <= line_width_q;
					len_q    <= word_length;
					last_q   <= last_word;
					used_q   <= USED_W'(word_length);
					walked_q <= '0;
					best_q   <= COST_MAX;
					extra_s1 <= line_width_q - word_length;
					pb_s1    <= prev_best_q;
				end
			end
			ST_WALK: begin
				if (walk_fit) begin
					used_q   <= used_n;
					walked_q <= walked_q + CNT_W'(1);
					extra_s1 <= width_q - used_n[LEN_W-1:0];
					pb_s1    <= front.pb;
				end
			end
			ST_RESTORE: walked_q <= walked_q - CNT_W'(1);
			ST_OUT: begin
				if (out_load) begin
					total_cost_q <= err_q ? COST_MAX : best_q;
					too_long_q   <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign total_cost = total_cost_q;
	assign too_long   = too_long_q;

	a_walk_has_words: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> cnt_q != '0)
		else $error("walk entered with an empty ring");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		walked_q <= cnt_q || state_q == ST_IDLE || state_q == ST_OUT)
		else $error("walk went past the stored words");
	a_pipe_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_WALK || state_q == ST_DRAIN))
		else $error("candidate outside a walk");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");

endmodule
`default_nettype wire
